[rtl/sch_pkg.sv]
// shared types and constants for the spin chain hamiltonian row generator
// no dependencies
`default_nettype none

package sch_pkg;

    localparam int MAX_SITES = 16;
    localparam int SITE_W    = $clog2(MAX_SITES);
    localparam int CNT_W     = $clog2(MAX_SITES + 1);
    localparam int STATE_W   = 16;
    localparam int VAL_W     = 16;
    localparam int ELEM_W    = 22;
    localparam int ACC_W     = 24;

    localparam logic [CNT_W-1:0] MIN_COUNT = CNT_W'(2);
    localparam logic [CNT_W-1:0] TOP_COUNT = CNT_W'(MAX_SITES);

    localparam logic signed [ACC_W-1:0] ELEM_MAX = ACC_W'(2097151);
    localparam logic signed [ACC_W-1:0] ELEM_MIN = -ACC_W'(2097152);

    localparam logic [VAL_W-1:0]   COUPLING_RESET = VAL_W'(256);
    localparam logic [CNT_W-1:0]   COUNT_RESET    = CNT_W'(8);

    typedef enum logic {
        CMD_LOAD     = 1'b0,
        CMD_GENERATE = 1'b1
    } t_cmd;

    typedef enum logic {
        REG_COUPLING   = 1'b0,
        REG_SITE_COUNT = 1'b1
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIAG = 4'b0010,
        S_EMIT = 4'b0100,
        S_OFF  = 4'b1000
    } t_state;

    typedef struct packed {
        logic clear;
        logic en;
        logic spin_up;
        logic anti;
    } t_acc_ctl;

endpackage

`default_nettype wire

[rtl/spin_chain_hamiltonian_row.sv]
// top level: sequencer, configuration registers and output register
// depends on sch_pkg, sch_field_tbl and sch_accum
`default_nettype none

// Emits one row of a periodic spin-chain Hamiltonian per generate item: the
// diagonal entry first, then one entry per antiparallel neighbour pair in
// increasing site order, with last set on the final entry. A load item
// writes one site field. For a generate item the diagonal sum runs one site
// per cycle through a single accumulator, and the pair scan then steps one
// site per cycle unless output back-pressure holds a pair entry, stopping
// after the last antiparallel bond. The diagonal entry also waits for output
// space. The input is not ready while a row is in progress; configuration
// is always ready.
module spin_chain_hamiltonian_row
    import sch_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic                     i_command,
    input  wire logic [SITE_W-1:0]        i_site,
    input  wire logic signed [VAL_W-1:0]  i_field_value,
    input  wire logic [STATE_W-1:0]       i_basis_state,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [STATE_W-1:0]            o_row,
    output logic [STATE_W-1:0]            o_column,
    output logic signed [ELEM_W-1:0]      o_element,
    output logic                          o_last,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic                     i_cfg_index,
    input  wire logic [VAL_W-1:0]         i_cfg_data
);

    t_state                  r_state, n_state;
    logic signed [VAL_W-1:0] r_coupling;
    logic [CNT_W-1:0]        r_site_count;
    logic [CNT_W-1:0]        r_n, n_n;
    logic [SITE_W-1:0]       r_j, n_j;
    logic [STATE_W-1:0]      r_st, n_st;
    logic [STATE_W-1:0]      r_row, n_row;
    logic [STATE_W-1:0]      r_rem, n_rem;
    logic                    r_out_valid, n_out_valid;
    logic [STATE_W-1:0]      r_out_row, n_out_row;
    logic [STATE_W-1:0]      r_out_col, n_out_col;
    logic signed [ELEM_W-1:0] r_out_elem, n_out_elem;
    logic                    r_out_last, n_out_last;

    logic                    w_in_acc;
    logic                    w_slot;
    logic [CNT_W-1:0]        w_n;
    logic [STATE_W-1:0]      w_full;
    logic [STATE_W-1:0]      w_st;
    logic [STATE_W-1:0]      w_rot;
    logic [CNT_W-1:0]        w_last_site;
    logic                    w_wrap;
    logic [SITE_W-1:0]       w_nx;
    logic [STATE_W-1:0]      w_flip;
    logic signed [ELEM_W-1:0] w_c_ext;
    logic signed [ELEM_W-1:0] w_off;
    logic signed [ELEM_W-1:0] w_diag;
    logic signed [VAL_W-1:0] w_field;
    logic                    w_tbl_we;
    t_acc_ctl                w_acc_ctl;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_slot      = !r_out_valid || i_out_ready;
    assign w_tbl_we    = w_in_acc && (t_cmd'(i_command) == CMD_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coupling   <= COUPLING_RESET;
            r_site_count <= COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg'(i_cfg_index))
                REG_COUPLING:   r_coupling   <= i_cfg_data;
                REG_SITE_COUNT: r_site_count <= i_cfg_data[CNT_W-1:0];
                default:        r_coupling   <= r_coupling;
            endcase
        end
    end

    // clamped site count, site mask, masked state and its rotation for the bond mask at accept
    always_comb begin
        if (r_site_count < MIN_COUNT) begin
            w_n = MIN_COUNT;
        end else if (r_site_count > TOP_COUNT) begin
            w_n = TOP_COUNT;
        end else begin
            w_n = r_site_count;
        end
        for (int i = 0; i < STATE_W; i++) begin
            w_full[i] = (CNT_W'(i) < w_n);
        end
        w_st = i_basis_state & w_full;
        for (int i = 0; i < STATE_W; i++) begin
            if (CNT_W'(i) == w_n - CNT_W'(1)) begin
                w_rot[i] = w_st[0];
            end else if (i < STATE_W - 1) begin
                w_rot[i] = w_st[(i + 1) % STATE_W];
            end else begin
                w_rot[i] = 1'b0;
            end
        end
    end

    assign w_last_site = r_n - CNT_W'(1);
    assign w_wrap      = ({1'b0, r_j} == w_last_site);
    assign w_nx        = w_wrap ? '0 : r_j + SITE_W'(1);
    assign w_flip      = (STATE_W'(1) << r_j) ^ (STATE_W'(1) << w_nx);
    assign w_c_ext     = {{(ELEM_W - VAL_W){r_coupling[VAL_W-1]}}, r_coupling};
    assign w_off       = (r_n == MIN_COUNT) ? (w_c_ext <<< 2) : (w_c_ext <<< 1);

    always_comb begin
        w_acc_ctl.clear   = w_in_acc;
        w_acc_ctl.en      = (r_state == S_DIAG);
        w_acc_ctl.spin_up = r_st[r_j];
        w_acc_ctl.anti    = r_rem[r_j];
    end

    sch_field_tbl u_tbl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_tbl_we),
        .i_waddr (i_site),
        .i_wdata (i_field_value),
        .i_raddr (r_j),
        .o_rdata (w_field)
    );

    sch_accum u_acc (
        .i_clk      (i_clk),
        .i_ctl      (w_acc_ctl),
        .i_field    (w_field),
        .i_coupling (r_coupling),
        .o_elem     (w_diag)
    );

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_j         = r_j;
        n_st        = r_st;
        n_row       = r_row;
        n_rem       = r_rem;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_elem  = r_out_elem;
        n_out_last  = r_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (t_cmd'(i_command) == CMD_GENERATE)) begin
                    n_n     = w_n;
                    n_st    = w_st;
                    n_row   = w_full ^ w_st;
                    n_rem   = (w_st ^ w_rot) & w_full;
                    n_j     = '0;
                    n_state = S_DIAG;
                end
            end
            S_DIAG: begin
                n_j = r_j + SITE_W'(1);
                if (w_wrap) begin
                    n_j     = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_row   = r_row;
                    n_out_col   = r_row;
                    n_out_elem  = w_diag;
                    n_out_last  = (r_rem == '0);
                    n_state     = (r_rem == '0) ? S_IDLE : S_OFF;
                end
            end
            S_OFF: begin
                if (!r_rem[0] || w_slot) begin
                    if (r_rem[0]) begin
                        n_out_valid = 1'b1;
                        n_out_row   = r_row;
                        n_out_col   = r_row ^ w_flip;
                        n_out_elem  = w_off;
                        n_out_last  = (r_rem[STATE_W-1:1] == '0);
                    end
                    n_rem = r_rem >> 1;
                    n_j   = r_j + SITE_W'(1);
                    if (r_rem[STATE_W-1:1] == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_j        <= n_j;
        r_st       <= n_st;
        r_row      <= n_row;
        r_rem      <= n_rem;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_elem <= n_out_elem;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_row       = r_out_row;
    assign o_column    = r_out_col;
    assign o_element   = r_out_elem;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

[rtl/sch_field_tbl.sv]
// per-site field table, one write port and one read port, cleared by reset
// depends on sch_pkg
`default_nettype none

module sch_field_tbl
    import sch_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_we,
    input  wire logic [SITE_W-1:0]       i_waddr,
    input  wire logic signed [VAL_W-1:0] i_wdata,
    input  wire logic [SITE_W-1:0]       i_raddr,
    output logic signed [VAL_W-1:0]      o_rdata
);

    logic signed [VAL_W-1:0] r_tbl [MAX_SITES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SITES; i++) begin
                r_tbl[i] <= '0;
            end
        end else if (i_we) begin
            r_tbl[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_tbl[i_raddr];

endmodule

`default_nettype wire

[rtl/sch_accum.sv]
// shared accumulator for the diagonal entry: adds one site term per cycle while enabled
// depends on sch_pkg
`default_nettype none

module sch_accum
    import sch_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire t_acc_ctl                i_ctl,
    input  wire logic signed [VAL_W-1:0] i_field,
    input  wire logic signed [VAL_W-1:0] i_coupling,
    output logic signed [ELEM_W-1:0]     o_elem
);

    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] w_f2;
    logic signed [ACC_W-1:0] w_c;
    logic signed [ACC_W-1:0] w_fterm;
    logic signed [ACC_W-1:0] w_cterm;

    always_comb begin
        w_f2    = {{(ACC_W - VAL_W - 1){i_field[VAL_W-1]}}, i_field, 1'b0};
        w_c     = {{(ACC_W - VAL_W){i_coupling[VAL_W-1]}}, i_coupling};
        w_fterm = i_ctl.spin_up ? w_f2 : -w_f2;
        w_cterm = i_ctl.anti ? -w_c : w_c;
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (i_ctl.en) begin
            n_acc = r_acc + w_fterm + w_cterm;
        end else begin
            n_acc = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // saturate to the element range
    always_comb begin
        if (r_acc > ELEM_MAX) begin
            o_elem = ELEM_MAX[ELEM_W-1:0];
        end else if (r_acc < ELEM_MIN) begin
            o_elem = ELEM_MIN[ELEM_W-1:0];
        end else begin
            o_elem = r_acc[ELEM_W-1:0];
        end
    end

endmodule

`default_nettype wire
